### rtl/imm_pkg.sv
package imm_pkg;

    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int DATA_W     = 32;
    localparam int CELL_W     = 2 * IDX_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;

    localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] REQ_COMPUTE    = 2'd2;

    localparam logic [APB_AW-3:0] REG_DIM = '0;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_WR_LEFT,
        OP_WR_RIGHT,
        OP_COMPUTE
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [CELL_W-1:0]   slot;
        logic [DATA_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

### rtl/imm_req_if.sv
interface imm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] elem_value;

    modport source (output valid, req_type, row, col, elem_value, input ready);
    modport sink (input valid, req_type, row, col, elem_value, output ready);
endinterface

### rtl/imm_rsp_if.sv
interface imm_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] product_value;
    logic               last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

### rtl/integer_matrix_multiply_unit.sv
// A load beat is taken every cycle while the four-entry command queue has room. An in-range
// beat is written to its matrix at the edge that removes it from the queue; others are dropped.
// A compute beat holds the back end while it steps through every i, j and k below d, d being the
// effective side; each result passes the matrix read, product and output registers in turn.
// Synchronous active-low reset empties the queue and pipeline and sets the side to 8.
// Matrix memories are not cleared by reset and hold undefined data until written.
module integer_matrix_multiply_unit import imm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    imm_req_if.sink           i_req,
    imm_rsp_if.source         o_rsp
);

    logic [DIM_W-1:0] r_dim;
    logic             fifo_full;
    logic             fifo_push;
    logic             fifo_pop;
    logic             fifo_valid;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    logic             reg_hit;

    assign reg_hit = (paddr[APB_AW-1:2] == REG_DIM);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? APB_DW'(r_dim) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_dim <= pwdata[DIM_W-1:0];
        end
    end

    imm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_req  (i_req),
        .i_full (fifo_full),
        .o_push (fifo_push),
        .o_cmd  (push_cmd)
    );

    imm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_cmd   (head_cmd),
        .o_valid (fifo_valid)
    );

    imm_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim       (r_dim),
        .i_cmd       (head_cmd),
        .i_cmd_valid (fifo_valid),
        .o_cmd_pop   (fifo_pop),
        .o_rsp       (o_rsp)
    );

endmodule

### rtl/imm_ram.sv
module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_re,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/imm_front.sv
module imm_front import imm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    imm_req_if.sink i_req,
    input  logic    i_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    logic keep;
    logic in_range;

    always_comb begin
        in_range = ({1'b0, i_req.row} < DIM_W'(MAX_DIM)) &&
                   ({1'b0, i_req.col} < DIM_W'(MAX_DIM));
        o_cmd.slot  = CELL_W'(i_req.row) * CELL_W'(MAX_DIM) + CELL_W'(i_req.col);
        o_cmd.value = i_req.elem_value;
        unique case (i_req.req_type)
            REQ_LOAD_LEFT: begin
                o_cmd.op = OP_WR_LEFT;
                keep     = in_range;
            end
            REQ_LOAD_RIGHT: begin
                o_cmd.op = OP_WR_RIGHT;
                keep     = in_range;
            end
            REQ_COMPUTE: begin
                o_cmd.op = OP_COMPUTE;
                keep     = 1'b1;
            end
            default: begin
                o_cmd.op = OP_COMPUTE;
                keep     = 1'b0;
            end
        endcase
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full && keep;

endmodule

### rtl/imm_cmd_fifo.sv
module imm_cmd_fifo import imm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr;
    logic [FIFO_PW-1:0] r_rd;
    logic [FIFO_PW:0]   r_count;

    logic do_pop;

    assign o_full  = (r_count == (FIFO_PW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/imm_back.sv
module imm_back import imm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_dim,
    input  t_cmd             i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_pop,
    imm_rsp_if.source        o_rsp
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int RAM_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_last_idx, n_last_idx;
    t_tag               r_s1, n_s1;
    t_tag               r_s2, n_s2;
    logic [DATA_W-1:0]  r_prod, n_prod;
    logic [DATA_W-1:0]  r_acc, n_acc;
    logic               r_out_v, n_out_v;
    logic [IDX_W-1:0]   r_out_row, n_out_row;
    logic [IDX_W-1:0]   r_out_col, n_out_col;
    logic [DATA_W-1:0]  r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    logic               advance;
    logic               issue;
    logic               we_left;
    logic               we_right;
    logic [DIM_W-1:0]   dim_eff;
    logic [DIM_W-1:0]   dim_m1;
    logic [CELL_W-1:0]  addr_left;
    logic [CELL_W-1:0]  addr_right;
    logic [DATA_W-1:0]  rd_left;
    logic [DATA_W-1:0]  rd_right;
    logic [DATA_W-1:0]  sum;

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_left_ram (
        .i_clk     (i_clk),
        .i_we      (we_left),
        .i_wr_addr (i_cmd.slot[RAM_AW-1:0]),
        .i_wr_data (i_cmd.value),
        .i_re      (issue),
        .i_rd_addr (addr_left[RAM_AW-1:0]),
        .o_rd_data (rd_left)
    );

    imm_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_right_ram (
        .i_clk     (i_clk),
        .i_we      (we_right),
        .i_wr_addr (i_cmd.slot[RAM_AW-1:0]),
        .i_wr_data (i_cmd.value),
        .i_re      (issue),
        .i_rd_addr (addr_right[RAM_AW-1:0]),
        .o_rd_data (rd_right)
    );

    always_comb begin
        if (i_dim == '0) begin
            dim_eff = DIM_W'(1);
        end else if (i_dim > DIM_W'(MAX_DIM)) begin
            dim_eff = DIM_W'(MAX_DIM);
        end else begin
            dim_eff = i_dim;
        end
        dim_m1 = dim_eff - 1'b1;

        addr_left  = CELL_W'(r_i) * CELL_W'(MAX_DIM) + CELL_W'(r_k);
        addr_right = CELL_W'(r_k) * CELL_W'(MAX_DIM) + CELL_W'(r_j);
        sum        = (r_s2.first ? '0 : r_acc) + r_prod;
        advance    = !(r_out_v && !o_rsp.ready);

        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_last_idx  = r_last_idx;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_v     = r_out_v;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        issue       = 1'b0;
        we_left     = 1'b0;
        we_right    = 1'b0;

        if (r_out_v && o_rsp.ready) begin
            n_out_v = 1'b0;
        end

        if (advance) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        o_cmd_pop = 1'b1;
                        unique case (i_cmd.op)
                            OP_WR_LEFT:  we_left  = 1'b1;
                            OP_WR_RIGHT: we_right = 1'b1;
                            OP_COMPUTE: begin
                                n_state    = ST_RUN;
                                n_i        = '0;
                                n_j        = '0;
                                n_k        = '0;
                                n_last_idx = dim_m1[IDX_W-1:0];
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    issue = 1'b1;
                    if (r_k == r_last_idx) begin
                        n_k = '0;
                        if (r_j == r_last_idx) begin
                            n_j = '0;
                            if (r_i == r_last_idx) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_i = r_i + 1'b1;
                            end
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
                default: n_state = ST_IDLE;
            endcase

            n_s1.valid  = issue;
            n_s1.first  = (r_k == '0);
            n_s1.last_k = (r_k == r_last_idx);
            n_s1.last   = (r_k == r_last_idx) && (r_j == r_last_idx) &&
                          (r_i == r_last_idx);
            n_s1.row    = r_i;
            n_s1.col    = r_j;
            n_s2        = r_s1;
            n_prod      = rd_left * rd_right;

            if (r_s2.valid) begin
                n_acc = sum;
                if (r_s2.last_k) begin
                    n_out_v     = 1'b1;
                    n_out_row   = r_s2.row;
                    n_out_col   = r_s2.col;
                    n_out_value = sum;
                    n_out_last  = r_s2.last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s1    <= '0;
            r_s2    <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_out_v <= n_out_v;
        end
        r_i         <= n_i;
        r_j         <= n_j;
        r_k         <= n_k;
        r_last_idx  <= n_last_idx;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.out_row       = r_out_row;
    assign o_rsp.out_col       = r_out_col;
    assign o_rsp.product_value = r_out_value;
    assign o_rsp.last          = r_out_last;

endmodule
